// ===== rtl/assert_macros.svh =====
// Assertion macros included by the core top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Condition that holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`endif

// ===== rtl/fdm_pkg.sv =====
// Types, constants and codes of the floor divmod core.
package fdm_pkg;
  localparam int DATA_WIDTH_DEF = 64;
  localparam int FIELD_W        = 64;

  localparam logic [2:0] ELEM_TYPE_RST = 3'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] quotient;
    logic [FIELD_W-1:0] remainder;
    logic [1:0]         status;
  } out_word_t;

  // Control that travels with each word down the pipeline.
  typedef struct packed {
    logic valid;
    logic is_signed;
    logic na;
    logic nb;
    logic divz;
    logic ovf;
  } ctl_t;
endpackage

// ===== rtl/fdm_pre.sv =====
// Operand stage: masking to element width, sign split, special cases.
module fdm_pre #(
  parameter int DW = fdm_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  input  logic [2:0]          elem_type_i,
  input  fdm_pkg::in_word_t   word_i,
  output fdm_pkg::ctl_t       ctl_o,
  output logic [DW-1:0]       ma_o,
  output logic [DW-1:0]       mb_o,
  output logic [DW-1:0]       a_o,
  output logic [DW-1:0]       b_o,
  output logic [DW-1:0]       mask_o
);
  import fdm_pkg::*;

  ctl_t          ctl_r, ctl_nxt;
  logic [DW-1:0] ma_r, mb_r, a_r, b_r, mask_r;
  logic [DW-1:0] mask, sbit, a, b;
  int            w;

  always_comb begin
    w = 8 << elem_type_i[1:0];
    if (w > DW) w = DW;
    mask = {DW{1'b1}} >> (DW - w);
    sbit = mask ^ (mask >> 1);
    a    = word_i.dividend[DW-1:0] & mask;
    b    = word_i.divisor[DW-1:0] & mask;
    ctl_nxt.valid     = valid_i;
    ctl_nxt.is_signed = !elem_type_i[2];
    ctl_nxt.na        = ctl_nxt.is_signed && ((a & sbit) != '0);
    ctl_nxt.nb        = ctl_nxt.is_signed && ((b & sbit) != '0);
    ctl_nxt.divz      = (b == '0);
    ctl_nxt.ovf       = ctl_nxt.is_signed && (a == sbit) && (b == mask);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ma_r   <= ctl_nxt.na ? ((-a) & mask) : a;
    mb_r   <= ctl_nxt.nb ? ((-b) & mask) : b;
    a_r    <= a;
    b_r    <= b;
    mask_r <= mask;
  end

  assign ctl_o  = ctl_r;
  assign ma_o   = ma_r;
  assign mb_o   = mb_r;
  assign a_o    = a_r;
  assign b_o    = b_r;
  assign mask_o = mask_r;
endmodule

// ===== rtl/fdm_stage.sv =====
// One restoring division step, registered.
module fdm_stage #(
  parameter int DW = fdm_pkg::DATA_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fdm_pkg::ctl_t    ctl_i,
  input  logic [DW-1:0]    rem_i,
  input  logic [DW-1:0]    q_i,
  input  logic [DW-1:0]    mb_i,
  input  logic [DW-1:0]    a_i,
  input  logic [DW-1:0]    b_i,
  input  logic [DW-1:0]    mask_i,
  output fdm_pkg::ctl_t    ctl_o,
  output logic [DW-1:0]    rem_o,
  output logic [DW-1:0]    q_o,
  output logic [DW-1:0]    mb_o,
  output logic [DW-1:0]    a_o,
  output logic [DW-1:0]    b_o,
  output logic [DW-1:0]    mask_o
);
  import fdm_pkg::*;

  ctl_t          ctl_r;
  logic [DW-1:0] rem_r, q_r, mb_r, a_r, b_r, mask_r;
  logic [DW-1:0] rem_nxt, q_nxt;
  logic [DW:0]   trial;

  // Shift the next dividend bit in and try the subtract.
  always_comb begin
    trial = {rem_i, q_i[DW-1]} - {1'b0, mb_i};
    if (!trial[DW]) begin
      rem_nxt = trial[DW-1:0];
      q_nxt   = {q_i[DW-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_i[DW-2:0], q_i[DW-1]};
      q_nxt   = {q_i[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    mb_r   <= mb_i;
    a_r    <= a_i;
    b_r    <= b_i;
    mask_r <= mask_i;
  end

  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign q_o    = q_r;
  assign mb_o   = mb_r;
  assign a_o    = a_r;
  assign b_o    = b_r;
  assign mask_o = mask_r;
endmodule

// ===== rtl/fdm_post.sv =====
// Result stage: sign restore, floor correction, special cases.
module fdm_post #(
  parameter int DW = fdm_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fdm_pkg::ctl_t      ctl_i,
  input  logic [DW-1:0]      uq_i,
  input  logic [DW-1:0]      ur_i,
  input  logic [DW-1:0]      a_i,
  input  logic [DW-1:0]      b_i,
  input  logic [DW-1:0]      mask_i,
  output logic               valid_o,
  output fdm_pkg::out_word_t word_o
);
  import fdm_pkg::*;

  logic          valid_r;
  out_word_t     word_r, word_nxt;
  logic [DW-1:0] q, r, sbit;

  always_comb begin
    sbit = mask_i ^ (mask_i >> 1);
    q    = (ctl_i.na != ctl_i.nb) ? -uq_i : uq_i;
    r    = ctl_i.na ? -ur_i : ur_i;
    if ((ur_i != '0) && (ctl_i.na != ctl_i.nb)) begin
      q = q - 1'b1;
      r = r + b_i;
    end
    word_nxt.status = ST_OK;
    if (ctl_i.divz) begin
      q = mask_i;
      r = a_i;
      word_nxt.status = ST_DIVZ;
    end else if (!ctl_i.is_signed) begin
      q = uq_i;
      r = ur_i;
    end else if (ctl_i.ovf) begin
      q = sbit;
      r = '0;
      word_nxt.status = ST_OVF;
    end
    word_nxt.quotient  = FIELD_W'(q & mask_i);
    word_nxt.remainder = FIELD_W'(r & mask_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;
endmodule

// ===== rtl/floor_divmod_core.sv =====
// Floor divmod core: pipelined integer division with floor-signed remainder.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+-------------------------------
//   input   | in_word                        | start, busy (always low)
//   result  | out_word                       | out_valid, one-cycle strobe
//   config  | cfg_data (element type)        | cfg_we, no wait
//
// One word enters per cycle; results leave in order after the operand stage,
// one restoring step per bit and the result stage.
// Throughput is set by the step chain being fully pipelined, one stage per bit.
// Synchronous active-low reset clears the valid bits and sets element type 2.
// The receiver cannot stall, so the pipeline never holds and busy stays low.
module floor_divmod_core #(
  parameter int DATA_WIDTH = fdm_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  fdm_pkg::in_word_t  in_word,
  output logic               out_valid,
  output fdm_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_data
);
  import fdm_pkg::*;
  `include "assert_macros.svh"

  localparam int DW  = DATA_WIDTH;
  localparam int LAT = DW + 2;

  logic [2:0] elem_type_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_type_r <= ELEM_TYPE_RST;
    end else if (cfg_we) begin
      elem_type_r <= cfg_data;
    end
  end

  assign busy = 1'b0;

  ctl_t          ctl  [0:DW];
  logic [DW-1:0] rem  [0:DW];
  logic [DW-1:0] q    [0:DW];
  logic [DW-1:0] mb   [0:DW];
  logic [DW-1:0] a    [0:DW];
  logic [DW-1:0] b    [0:DW];
  logic [DW-1:0] mask [0:DW];

  fdm_pre #(.DW(DW)) u_pre (
    .clk, .rst_n,
    .valid_i(start && !busy), .elem_type_i(elem_type_r), .word_i(in_word),
    .ctl_o(ctl[0]), .ma_o(q[0]), .mb_o(mb[0]), .a_o(a[0]), .b_o(b[0]),
    .mask_o(mask[0])
  );

  assign rem[0] = '0;

  for (genvar i = 0; i < DW; i++) begin : g_step
    fdm_stage #(.DW(DW)) u_stage (
      .clk, .rst_n,
      .ctl_i(ctl[i]), .rem_i(rem[i]), .q_i(q[i]), .mb_i(mb[i]),
      .a_i(a[i]), .b_i(b[i]), .mask_i(mask[i]),
      .ctl_o(ctl[i+1]), .rem_o(rem[i+1]), .q_o(q[i+1]), .mb_o(mb[i+1]),
      .a_o(a[i+1]), .b_o(b[i+1]), .mask_o(mask[i+1])
    );
  end

  fdm_post #(.DW(DW)) u_post (
    .clk, .rst_n,
    .ctl_i(ctl[DW]), .uq_i(q[DW]), .ur_i(rem[DW]), .a_i(a[DW]), .b_i(b[DW]),
    .mask_i(mask[DW]), .valid_o(out_valid), .word_o(out_word)
  );

  `ASSERT_IMPLY(a_latency, clk, rst_n, start, ##LAT out_valid)
  `ASSERT_IMPLY(a_status_code, clk, rst_n, out_valid,
    out_word.status == ST_OK || out_word.status == ST_DIVZ || out_word.status == ST_OVF)
  `ASSERT_IMPLY(a_divz_q, clk, rst_n, out_valid && out_word.status == ST_DIVZ,
    out_word.quotient[0])
  `ASSERT_IMPLY(a_ovf_r, clk, rst_n, out_valid && out_word.status == ST_OVF,
    out_word.remainder == '0)
endmodule

// ===== test/floor_divmod_core_tb.sv =====
// Testbench of the floor divmod core: queued driver, strobe monitor, predicted quotients, remainders and status.
module floor_divmod_core_tb;
  import fdm_pkg::*;

  localparam int LATENCY = DATA_WIDTH_DEF + 2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_word = '0;
  logic out_valid;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_data = '0;

  floor_divmod_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  logic [2:0] elem_type = ELEM_TYPE_RST;
  int errors = 0;
  int gap_left = 0;
  bit driver_hold = 1'b0;

  function automatic out_word_t floor_divmod(in_word_t w, logic [2:0] et);
    int unsigned width;
    logic [63:0] mask, sbit, a, b, ma, mb, uq, ur, q, r;
    logic na, nb;
    out_word_t res;
    width = 8 << et[1:0];
    mask = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
    sbit = 64'd1 << (width - 1);
    a = w.dividend & mask;
    b = w.divisor & mask;
    res.status = ST_OK;
    if (b == '0) begin
      q = mask;
      r = a;
      res.status = ST_DIVZ;
    end else if (et[2]) begin
      q = a / b;
      r = a % b;
    end else if (a == sbit && b == mask) begin
      q = sbit;
      r = '0;
      res.status = ST_OVF;
    end else begin
      na = (a & sbit) != '0;
      nb = (b & sbit) != '0;
      ma = na ? ((64'd0 - a) & mask) : a;
      mb = nb ? ((64'd0 - b) & mask) : b;
      uq = ma / mb;
      ur = ma % mb;
      q = (na != nb) ? (64'd0 - uq) : uq;
      r = na ? (64'd0 - ur) : ur;
      if (ur != '0 && na != nb) begin
        q = q - 64'd1;
        r = r + b;
      end
    end
    res.quotient = q & mask;
    res.remainder = r & mask;
    return res;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // Driver: prediction is made when a word is accepted, using the live element type.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_words.push_back(floor_divmod(in_word, elem_type));
      pending_words.pop_front();
    end
    if (!rst_n || driver_hold) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      gap_left = pick_gap();
      if (gap_left == 0 && pending_words.size() > 0) begin
        in_word <= pending_words[0];
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end else if (start) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (pending_words.size() > 0) begin
      in_word <= pending_words[0];
      start <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $error("result word with none expected");
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_word.quotient !== exp_w.quotient) begin
          $error("quotient expected %h actual %h", exp_w.quotient, out_word.quotient);
          errors++;
        end
        if (out_word.remainder !== exp_w.remainder) begin
          $error("remainder expected %h actual %h", exp_w.remainder, out_word.remainder);
          errors++;
        end
        if (out_word.status !== exp_w.status) begin
          $error("status expected %0d actual %0d", exp_w.status, out_word.status);
          errors++;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Operand biased toward the edges of the element range.
  function automatic logic [63:0] pick_operand(int unsigned width);
    logic [63:0] v;
    logic [63:0] sbit;
    sbit = 64'd1 << (width - 1);
    case ($urandom_range(9))
      0: v = '0;
      1: v = 64'd1;
      2: v = '1;
      3: v = sbit;
      4: v = sbit - 64'd1;
      5: v = 64'($urandom_range(7));
      6: v = 64'd0 - 64'($urandom_range(7));
      default: v = rand64();
    endcase
    if ($urandom_range(1)) v = v ^ (rand64() & ~((width == 64) ? '1 : ((64'd1 << width) - 1)));
    return v;
  endfunction

  task automatic push_word(logic [63:0] a, logic [63:0] b);
    in_word_t w;
    w.dividend = a;
    w.divisor = b;
    pending_words.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || start || expected_words.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_elem_type(logic [2:0] et);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= et;
    @(posedge clk);
    cfg_we <= 1'b0;
    elem_type = et;
  endtask

  initial begin
    logic [63:0] sb;
    int unsigned width;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // Directed words under the reset element type (signed 32-bit).
    push_word(64'd7, 64'd2);
    push_word(-64'd7, 64'd2);
    push_word(64'd7, -64'd2);
    push_word(-64'd7, -64'd2);
    push_word(64'd6, -64'd3);
    push_word(64'd5, 64'd0);
    push_word(64'h8000_0000, 64'hFFFF_FFFF);
    push_word(64'hDEAD_BEEF_8000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    push_word('1, '1);
    push_word(64'h7FFF_FFFF, 64'h8000_0000);
    push_word(64'h8000_0000, 64'd1);
    push_word(64'h1234_5678_0000_0000, 64'h0000_0000);
    wait_drained();
    for (int et = 7; et >= 0; et--) begin
      write_elem_type(et[2:0]);
      width = 8 << et[1:0];
      sb = 64'd1 << (width - 1);
      push_word(sb, -64'd1);
      push_word(-64'd1, 64'd0);
      push_word('1, 64'd1);
      push_word(sb, sb);
      push_word(-64'd5, 64'd3);
      if (et == 3) begin
        // Sender pause: hold until all expected words have come.
        while (pending_words.size() > 0 || start) @(posedge clk);
        driver_hold = 1'b1;
        while (expected_words.size() > 0) @(posedge clk);
        driver_hold = 1'b0;
      end
      for (int i = 0; i < 110; i++) push_word(pick_operand(width), pick_operand(width));
      wait_drained();
    end
    write_elem_type(3'($urandom_range(7)));
    for (int i = 0; i < 20; i++) push_word(rand64(), rand64());
    wait_drained();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fdm_pkg.sv
rtl/fdm_pre.sv
rtl/fdm_stage.sv
rtl/fdm_post.sv
rtl/floor_divmod_core.sv
test/floor_divmod_core_tb.sv
